@@ rtl/cimh_pkg.sv @@
// ----------------------------------------------------------------------------
// cimh_pkg
// Types, constants and helpers shared by the cut-scan mass histogrammer.
// ----------------------------------------------------------------------------
package cimh_pkg;

  localparam int MAX_CUTS   = 16;
  localparam int BINS       = 100;
  localparam int COUNT_BITS = 32;

  localparam int HIST_DEPTH = MAX_CUTS * BINS;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int CUT_W      = $clog2(MAX_CUTS + 1);
  localparam int BIN_W      = $clog2(BINS);

  localparam int MOM_W  = 24;   // held momentum component
  localparam int VAL_W  = 25;   // mass / energy sum
  localparam int SUM_W  = 26;   // signed momentum sum
  localparam int SQ_W   = 50;   // square of a 25 bit magnitude
  localparam int ACC_W  = 53;   // e^2 - x^2 - y^2 - z^2, two's complement
  localparam int ROOT_W = 51;   // square root working width
  localparam int WID_W  = 10;   // bin width
  localparam int THR_W  = 22;   // score threshold

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_HEADER   = 2'd0;
  localparam logic [1:0] CMD_PARTICLE = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;
  localparam logic [1:0] CMD_SPARE    = 2'd3;

  localparam logic [1:0] PART_PSI  = 2'd0;
  localparam logic [1:0] PART_PIM  = 2'd1;
  localparam logic [1:0] PART_PIP1 = 2'd2;
  localparam logic [1:0] PART_PIP2 = 2'd3;

  localparam logic HIST_PARENT = 1'b0;
  localparam logic HIST_TRIPLE = 1'b1;

  localparam logic [2:0] REG_CUT_START        = 3'd0;
  localparam logic [2:0] REG_CUT_STEP         = 3'd1;
  localparam logic [2:0] REG_CUT_COUNT        = 3'd2;
  localparam logic [2:0] REG_PARENT_HIST_LOW  = 3'd3;
  localparam logic [2:0] REG_PARENT_BIN_WIDTH = 3'd4;
  localparam logic [2:0] REG_TRIPLE_HIST_LOW  = 3'd5;
  localparam logic [2:0] REG_TRIPLE_BIN_WIDTH = 3'd6;
  localparam logic [2:0] REG_PARENT_GATE      = 3'd7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         particle;
    logic [22:0]        energy;
    logic signed [23:0] mom_x;
    logic signed [23:0] mom_y;
    logic signed [23:0] mom_z;
    logic signed [15:0] score;
    logic [15:0]        parent_mass;
    logic [3:0]         cut_index;
    logic [6:0]         bin_index;
  } item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [4:0]  cuts_passed;
    logic [24:0] mass_first;
    logic [24:0] mass_second;
    logic        masses_valid;
  } result_t;

  typedef struct packed {
    logic                  parent_en;
    logic                  triple_en;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } hist_wr_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CUT,
    ST_SUM,
    ST_SQ,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_FILL_CHK,
    ST_DIV,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_READ_RD,
    ST_READ_DAT,
    ST_DONE
  } state_t;

  function automatic logic [31:0] sat_count(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] hi;
    hi = c >> 32;
    if (hi != '0) return '1;
    return 32'(c);
  endfunction

endpackage

@@ rtl/cimh_hist_mem.sv @@
// ----------------------------------------------------------------------------
// cimh_hist_mem
// Parent and three-body histogram memories, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module cimh_hist_mem (
  input  logic                             clk,
  input  cimh_pkg::hist_wr_t               wr,
  input  logic [cimh_pkg::ADDR_W-1:0]      rd_addr,
  output logic [cimh_pkg::COUNT_BITS-1:0]  parent_q,
  output logic [cimh_pkg::COUNT_BITS-1:0]  triple_q
);
  import cimh_pkg::*;

  logic [COUNT_BITS-1:0] parent_mem [HIST_DEPTH];
  logic [COUNT_BITS-1:0] triple_mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.parent_en) begin
      parent_mem[wr.addr] <= wr.data;
    end
    parent_q <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.triple_en) begin
      triple_mem[wr.addr] <= wr.data;
    end
    triple_q <= triple_mem[rd_addr];
  end

endmodule

@@ rtl/cut_scan_invariant_mass_histogrammer.sv @@
// ----------------------------------------------------------------------------
// cut_scan_invariant_mass_histogrammer
// Score cut scan with parent and three-body invariant mass histograms.
// ----------------------------------------------------------------------------
//  channel  signals                        direction
//  item     item_valid/item_ready/item     in
//  result   result_valid/result_ready      out
//  cfg      cfg_valid/cfg_ready/index/data in
//
//  one item at a time; a read passes READ_RD, READ_DAT and DONE, other
//  particle items go to DONE; header: CUT per threshold passed plus one,
//  then FILL_CHK, DIV for the bin division, FILL_RD/FILL_WR per cut passed
//  pip2 with gate open: sums, squares and root per mass in SUM, SQ, ROOT_INIT,
//  ROOT, then divider, then a memory read-modify-write per update
//  after reset a clearing pass over all 1600 addresses blocks items
//  a waiting result holds the next item only at its final cycle
// ----------------------------------------------------------------------------
module cut_scan_invariant_mass_histogrammer (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  cimh_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output cimh_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import cimh_pkg::*;

  // configuration
  logic signed [15:0] cut_start;
  logic [15:0]        cut_step;
  logic [4:0]         cut_count;
  logic [15:0]        parent_hist_low;
  logic [WID_W-1:0]   parent_bin_width;
  logic [15:0]        triple_hist_low;
  logic [WID_W-1:0]   triple_bin_width;
  logic [15:0]        parent_gate;

  state_t state, state_next, after_fill;

  item_t              it;
  logic signed [MOM_W-1:0] held [3][4];
  logic [CUT_W-1:0]   event_cuts_passed;
  logic               event_gate_open;

  logic [ADDR_W-1:0]  clr_addr;
  logic [CUT_W-1:0]   cut_j;
  logic signed [THR_W-1:0] thr;

  logic               mass_k;
  logic [VAL_W-1:0]   e_sum;
  logic signed [SUM_W-1:0] x_sum, y_sum, z_sum;
  logic [2:0]         sq_cnt;
  logic [VAL_W-1:0]   sq_op;
  logic [SQ_W-1:0]    prod;
  logic [ACC_W-1:0]   acc;
  logic [ROOT_W-1:0]  rv, rr, rbit, rt, rv_next, rr_next;
  logic               root_ge;

  logic               fill_sel;
  logic [VAL_W-1:0]   fill_val;
  logic [WID_W-1:0]   fill_width;
  logic [15:0]        fill_low;
  logic [VAL_W-1:0]   div_dq, div_dq_next;
  logic [WID_W-1:0]   div_rem, div_rem_next;
  logic [WID_W:0]     rem_t;
  logic               div_ge;
  logic [4:0]         div_cnt;
  logic [ADDR_W-1:0]  fill_base, fill_addr;
  logic [CUT_W-1:0]   fill_j;

  logic [31:0]        res_count;
  logic [VAL_W-1:0]   m1, m2;
  logic               mvalid;

  hist_wr_t           hwr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COUNT_BITS-1:0] parent_q, triple_q, cur_q;

  logic [CUT_W-1:0]   n_eff;
  logic               cut_pass, read_ok, accept;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  assign n_eff    = (32'(cut_count) > MAX_CUTS) ? CUT_W'(MAX_CUTS) : CUT_W'(cut_count);
  assign cut_pass = (cut_j < n_eff) && (THR_W'(it.score) > thr);
  assign read_ok  = (item.particle < 2'd2) && (32'(item.cut_index) < MAX_CUTS)
                  && (32'(item.bin_index) < BINS);

  assign fill_width = (fill_sel == HIST_TRIPLE) ? triple_bin_width : parent_bin_width;
  assign fill_low   = (fill_sel == HIST_TRIPLE) ? triple_hist_low : parent_hist_low;
  assign fill_addr  = fill_base + ADDR_W'(div_dq[BIN_W-1:0]);
  assign cur_q      = (fill_sel == HIST_TRIPLE) ? triple_q : parent_q;

  // restoring divider step, one quotient bit a cycle
  assign rem_t        = {div_rem, div_dq[VAL_W-1]};
  assign div_ge       = rem_t >= (WID_W+1)'(fill_width);
  assign div_rem_next = div_ge ? WID_W'(rem_t - (WID_W+1)'(fill_width)) : WID_W'(rem_t);
  assign div_dq_next  = {div_dq[VAL_W-2:0], div_ge};

  // integer square root step, two radicand bits a cycle
  assign rt      = rr + rbit;
  assign root_ge = rv >= rt;
  assign rv_next = root_ge ? rv - rt : rv;
  assign rr_next = root_ge ? (rr >> 1) + rbit : rr >> 1;

  always_comb begin
    case (sq_cnt)
      3'd0:    sq_op = e_sum;
      3'd1:    sq_op = x_sum[SUM_W-1] ? VAL_W'(-x_sum) : VAL_W'(x_sum);
      3'd2:    sq_op = y_sum[SUM_W-1] ? VAL_W'(-y_sum) : VAL_W'(y_sum);
      default: sq_op = z_sum[SUM_W-1] ? VAL_W'(-z_sum) : VAL_W'(z_sum);
    endcase
  end

  always_comb begin
    after_fill = (fill_sel == HIST_PARENT || mass_k) ? ST_DONE : ST_SUM;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(HIST_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item.cmd)
            CMD_HEADER:   state_next = ST_CUT;
            CMD_PARTICLE: state_next = (item.particle == PART_PIP2 && event_gate_open)
                                       ? ST_SUM : ST_DONE;
            CMD_READ:     state_next = read_ok ? ST_READ_RD : ST_DONE;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_CUT: begin
        if (!cut_pass) state_next = ST_FILL_CHK;
      end
      ST_SUM:       state_next = ST_SQ;
      ST_SQ: begin
        if (sq_cnt == 3'd4) state_next = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: state_next = acc[ACC_W-1] ? after_fill : ST_ROOT;
      ST_ROOT: begin
        if (rbit == ROOT_W'(1)) state_next = ST_FILL_CHK;
      end
      ST_FILL_CHK: begin
        if (fill_width == '0 || fill_val < VAL_W'(fill_low)) state_next = after_fill;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == 5'(VAL_W - 1)) begin
          state_next = (div_dq_next < VAL_W'(BINS) && event_cuts_passed != '0)
                       ? ST_FILL_RD : after_fill;
        end
      end
      ST_FILL_RD:   state_next = ST_FILL_WR;
      ST_FILL_WR: begin
        state_next = (fill_j + CUT_W'(1) < event_cuts_passed) ? ST_FILL_RD : after_fill;
      end
      ST_READ_RD:   state_next = ST_READ_DAT;
      ST_READ_DAT:  state_next = ST_DONE;
      ST_DONE: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    hwr     = '0;
    rd_addr = fill_addr;
    unique case (state)
      ST_CLEAR: begin
        hwr.parent_en = 1'b1;
        hwr.triple_en = 1'b1;
        hwr.addr      = clr_addr;
      end
      ST_FILL_WR: begin
        hwr.parent_en = (fill_sel == HIST_PARENT);
        hwr.triple_en = (fill_sel == HIST_TRIPLE);
        hwr.addr      = fill_addr;
        hwr.data      = (cur_q == COUNT_MAX) ? cur_q : cur_q + COUNT_BITS'(1);
      end
      ST_READ_RD: begin
        rd_addr = ADDR_W'(it.cut_index) * ADDR_W'(BINS) + ADDR_W'(it.bin_index);
      end
      default: begin
        rd_addr = fill_addr;
      end
    endcase
  end

  cimh_hist_mem u_mem (
    .clk      (clk),
    .wr       (hwr),
    .rd_addr  (rd_addr),
    .parent_q (parent_q),
    .triple_q (triple_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_start        <= '0;
      cut_step         <= 16'd1638;
      cut_count        <= 5'd16;
      parent_hist_low  <= 16'd5800;
      parent_bin_width <= 10'd10;
      triple_hist_low  <= 16'd3580;
      triple_bin_width <= 10'd2;
      parent_gate      <= 16'd6357;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CUT_START:        cut_start        <= cfg_data;
        REG_CUT_STEP:         cut_step         <= cfg_data;
        REG_CUT_COUNT:        cut_count        <= cfg_data[4:0];
        REG_PARENT_HIST_LOW:  parent_hist_low  <= cfg_data;
        REG_PARENT_BIN_WIDTH: parent_bin_width <= cfg_data[WID_W-1:0];
        REG_TRIPLE_HIST_LOW:  triple_hist_low  <= cfg_data;
        REG_TRIPLE_BIN_WIDTH: triple_bin_width <= cfg_data[WID_W-1:0];
        REG_PARENT_GATE:      parent_gate      <= cfg_data;
        default: ;
      endcase
    end
  end

  // event state and held particles
  always_ff @(posedge clk) begin
    if (rst) begin
      event_cuts_passed <= '0;
      event_gate_open   <= 1'b0;
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 4; c++) begin
          held[p][c] <= '0;
        end
      end
    end else begin
      if (accept && item.cmd == CMD_PARTICLE && item.particle != PART_PIP2) begin
        held[item.particle][0] <= MOM_W'(item.energy);
        held[item.particle][1] <= item.mom_x;
        held[item.particle][2] <= item.mom_y;
        held[item.particle][3] <= item.mom_z;
      end
      if (state == ST_CUT && !cut_pass) begin
        event_cuts_passed <= cut_j;
        event_gate_open   <= it.parent_mass > parent_gate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (state == ST_DONE && state_next == ST_IDLE) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      it        <= item;
      cut_j     <= '0;
      thr       <= THR_W'(cut_start);
      mass_k    <= 1'b0;
      res_count <= '0;
      m1        <= '0;
      m2        <= '0;
      mvalid    <= (item.cmd == CMD_PARTICLE && item.particle == PART_PIP2
                    && event_gate_open);
    end
    case (state)
      ST_CUT: begin
        if (cut_pass) begin
          cut_j <= cut_j + CUT_W'(1);
          thr   <= thr + THR_W'(cut_step);
        end else begin
          fill_sel <= HIST_PARENT;
          fill_val <= VAL_W'(it.parent_mass);
        end
      end
      ST_SUM: begin
        // psi + pim + (pip1 on the first mass, pip2 item on the second)
        fill_sel <= HIST_TRIPLE;
        e_sum  <= VAL_W'(held[PART_PSI][0]) + VAL_W'(held[PART_PIM][0])
                + (mass_k ? VAL_W'(it.energy) : VAL_W'(held[PART_PIP1][0]));
        x_sum  <= SUM_W'(held[PART_PSI][1]) + SUM_W'(held[PART_PIM][1])
                + (mass_k ? SUM_W'(it.mom_x) : SUM_W'(held[PART_PIP1][1]));
        y_sum  <= SUM_W'(held[PART_PSI][2]) + SUM_W'(held[PART_PIM][2])
                + (mass_k ? SUM_W'(it.mom_y) : SUM_W'(held[PART_PIP1][2]));
        z_sum  <= SUM_W'(held[PART_PSI][3]) + SUM_W'(held[PART_PIM][3])
                + (mass_k ? SUM_W'(it.mom_z) : SUM_W'(held[PART_PIP1][3]));
        sq_cnt <= '0;
      end
      ST_SQ: begin
        if (sq_cnt != 3'd4) prod <= sq_op * sq_op;
        if (sq_cnt == 3'd1) acc <= ACC_W'(prod);
        else if (sq_cnt != 3'd0) acc <= acc - ACC_W'(prod);
        sq_cnt <= sq_cnt + 3'd1;
      end
      ST_ROOT_INIT: begin
        rv   <= ROOT_W'(acc);
        rr   <= '0;
        rbit <= ROOT_W'(1) << (ROOT_W - 1);
        if (acc[ACC_W-1] && !mass_k) mass_k <= 1'b1;
      end
      ST_ROOT: begin
        rv   <= rv_next;
        rr   <= rr_next;
        rbit <= rbit >> 2;
        if (rbit == ROOT_W'(1)) begin
          fill_sel <= HIST_TRIPLE;
          fill_val <= VAL_W'(rr_next);
          if (mass_k) m2 <= VAL_W'(rr_next);
          else m1 <= VAL_W'(rr_next);
        end
      end
      ST_FILL_CHK: begin
        div_dq  <= fill_val - VAL_W'(fill_low);
        div_rem <= '0;
        div_cnt <= '0;
        if (state_next == ST_SUM) mass_k <= 1'b1;
      end
      ST_DIV: begin
        div_dq    <= div_dq_next;
        div_rem   <= div_rem_next;
        div_cnt   <= div_cnt + 5'd1;
        fill_base <= '0;
        fill_j    <= '0;
        if (state_next == ST_SUM) mass_k <= 1'b1;
      end
      ST_FILL_WR: begin
        fill_base <= fill_base + ADDR_W'(BINS);
        fill_j    <= fill_j + CUT_W'(1);
        if (state_next == ST_SUM) mass_k <= 1'b1;
      end
      ST_READ_DAT: begin
        res_count <= sat_count((it.particle[0] == HIST_TRIPLE) ? triple_q : parent_q);
      end
      ST_DONE: begin
        if (state_next == ST_IDLE) begin
          result.bin_count    <= res_count;
          result.cuts_passed  <= 5'(event_cuts_passed);
          result.mass_first   <= m1;
          result.mass_second  <= m2;
          result.masses_valid <= mvalid;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/cimh_checker.sv @@
// ----------------------------------------------------------------------------
// cimh_port_assertions
// Port-level checks for the cut-scan mass histogrammer, bound to the top.
// ----------------------------------------------------------------------------
module cimh_port_assertions (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input cimh_pkg::result_t   result
);
  import cimh_pkg::*;

  // a stalled result transaction keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item in flight: an accepted item closes the input on the following cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while busy");

  // masses only come with a valid flag, never with a bin count
  a_mass_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.masses_valid |-> result.mass_first == '0
                                          && result.mass_second == '0)
    else $error("mass without valid flag");

  a_mass_nocount: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.masses_valid |-> result.bin_count == '0)
    else $error("bin count on a mass result");

  a_cuts_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 32'(result.cuts_passed) <= MAX_CUTS)
    else $error("cuts passed out of range");

endmodule

bind cut_scan_invariant_mass_histogrammer cimh_port_assertions u_port_assertions (.*);

@@ bench/cimh_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cimh_checker
// Watches the item, result and register channels of the mass histogrammer,
// keeps its own copy of the histograms and event state, and compares every
// result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module cimh_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  cimh_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  cimh_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending
);
  import cimh_pkg::*;

  localparam longint unsigned SAT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;

  logic signed [15:0] thr_start;
  logic [15:0] thr_step;
  logic [4:0]  n_cuts;
  logic [15:0] par_low;
  logic [9:0]  par_width;
  logic [15:0] tri_low;
  logic [9:0]  tri_width;
  logic [15:0] gate_mass;

  longint unsigned par_counts[HIST_DEPTH];
  longint unsigned tri_counts[HIST_DEPTH];
  longint held[12];
  int unsigned ev_cuts;
  bit ev_gate;

  result_t expected_q[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // negative mass square gives zero and no fill
  function automatic longint unsigned body_mass(longint e, longint x, longint y, longint z,
                                                output bit ok);
    longint sq;
    sq = e * e - x * x - y * y - z * z;
    ok = (sq >= 0);
    if (!ok) return 0;
    return floor_root(longint'(sq));
  endfunction

  task automatic add_counts(bit to_triple, int unsigned cuts, longint unsigned value,
                            longint unsigned low, longint unsigned width);
    longint unsigned bin;
    int idx;
    if (width == 0 || value < low) return;
    bin = (value - low) / width;
    if (bin >= BINS) return;
    for (int j = 0; j < cuts && j < MAX_CUTS; j++) begin
      idx = j * BINS + int'(bin);
      if (to_triple) begin
        if (tri_counts[idx] < SAT_LIMIT) tri_counts[idx]++;
      end else begin
        if (par_counts[idx] < SAT_LIMIT) par_counts[idx]++;
      end
    end
  endtask

  task automatic predict_result(input item_t it, output result_t r);
    longint mom[4];
    longint score;
    longint thr;
    int unsigned n;
    int unsigned passed;
    longint unsigned ma, mb, cnt;
    bit ok_a, ok_b;
    int idx;
    r = '0;
    mom[0] = longint'(it.energy);
    mom[1] = longint'(it.mom_x);
    mom[2] = longint'(it.mom_y);
    mom[3] = longint'(it.mom_z);
    case (it.cmd)
      CMD_HEADER: begin
        score = longint'(it.score);
        n = (n_cuts > MAX_CUTS) ? MAX_CUTS : n_cuts;
        passed = 0;
        for (int j = 0; j < n; j++) begin
          thr = longint'(thr_start) + longint'(j) * longint'(thr_step);
          if (score > thr) passed++;
          else break;
        end
        ev_cuts = passed;
        ev_gate = (it.parent_mass > gate_mass);
        add_counts(1'b0, passed, it.parent_mass, par_low, par_width);
      end
      CMD_PARTICLE: begin
        if (it.particle != PART_PIP2) begin
          for (int k = 0; k < 4; k++) held[it.particle * 4 + k] = mom[k];
        end else if (ev_gate) begin
          // psi + pip1 + pim, then psi + pip2 + pim
          ma = body_mass(held[0] + held[8] + held[4], held[1] + held[9] + held[5],
                         held[2] + held[10] + held[6], held[3] + held[11] + held[7], ok_a);
          mb = body_mass(held[0] + mom[0] + held[4], held[1] + mom[1] + held[5],
                         held[2] + mom[2] + held[6], held[3] + mom[3] + held[7], ok_b);
          if (ok_a) add_counts(1'b1, ev_cuts, ma, tri_low, tri_width);
          if (ok_b) add_counts(1'b1, ev_cuts, mb, tri_low, tri_width);
          r.mass_first   = ma[24:0];
          r.mass_second  = mb[24:0];
          r.masses_valid = 1'b1;
        end
      end
      CMD_READ: begin
        if (it.particle < 2 && it.cut_index < MAX_CUTS && it.bin_index < BINS) begin
          idx = int'(it.cut_index) * BINS + int'(it.bin_index);
          cnt = (it.particle[0] == HIST_PARENT) ? par_counts[idx] : tri_counts[idx];
          if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
          r.bin_count = cnt[31:0];
        end
      end
      default: ;
    endcase
    r.cuts_passed = ev_cuts[4:0];
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    result_t new_r;
    if (rst) begin
      thr_start = 16'sd0;
      thr_step  = 16'd1638;
      n_cuts    = 5'd16;
      par_low   = 16'd5800;
      par_width = 10'd10;
      tri_low   = 16'd3580;
      tri_width = 10'd2;
      gate_mass = 16'd6357;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        par_counts[i] = 0;
        tri_counts[i] = 0;
      end
      for (int i = 0; i < 12; i++) held[i] = 0;
      ev_cuts = 0;
      ev_gate = 0;
      expected_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CUT_START:        thr_start = cfg_data;
          REG_CUT_STEP:         thr_step  = cfg_data;
          REG_CUT_COUNT:        n_cuts    = cfg_data[4:0];
          REG_PARENT_HIST_LOW:  par_low   = cfg_data;
          REG_PARENT_BIN_WIDTH: par_width = cfg_data[9:0];
          REG_TRIPLE_HIST_LOW:  tri_low   = cfg_data;
          REG_TRIPLE_BIN_WIDTH: tri_width = cfg_data[9:0];
          REG_PARENT_GATE:      gate_mass = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result transaction %h", $realtime, result);
        end else begin
          exp_r = expected_q.pop_front();
          if (result.bin_count !== exp_r.bin_count ||
              result.cuts_passed !== exp_r.cuts_passed ||
              result.mass_first !== exp_r.mass_first ||
              result.mass_second !== exp_r.mass_second ||
              result.masses_valid !== exp_r.masses_valid) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch count %0d/%0d cuts %0d/%0d m1 %0d/%0d m2 %0d/%0d v %0b/%0b",
                       $realtime, exp_r.bin_count, result.bin_count,
                       exp_r.cuts_passed, result.cuts_passed,
                       exp_r.mass_first, result.mass_first,
                       exp_r.mass_second, result.mass_second,
                       exp_r.masses_valid, result.masses_valid);
          end
        end
      end
      if (item_valid && item_ready) begin
        predict_result(item, new_r);
        expected_q.insert(expected_q.size(), new_r);
      end
      pending = expected_q.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cut-scan mass histogrammer: directed items, then phases
// of random events, reads and noise under several register settings, with
// bursty sending and a stalling receiver. The checker gives the failures.
// ----------------------------------------------------------------------------
module tb_top;
  import cimh_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 400;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int errors;
  int pending;
  int cycles;
  int sent;
  int burst_left;
  int rx_mode;
  int rx_left;
  int rx_hold;

  cut_scan_invariant_mass_histogrammer dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cimh_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, switching mode now and then
  always @(negedge clk) begin
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) rx_hold = $urandom_range(1, 30);
        rx_hold--;
        rdy = (rx_hold == 0);
      end
    endcase
    result_ready <= rdy;
  end

  function automatic item_t noise_item();
    item_t it;
    logic [159:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  function automatic item_t header_item(logic signed [15:0] score, logic [15:0] pm);
    item_t it;
    it = noise_item();
    it.cmd = CMD_HEADER;
    it.score = score;
    it.parent_mass = pm;
    return it;
  endfunction

  function automatic item_t particle_item(logic [1:0] p, logic [22:0] e,
                                          logic signed [23:0] x, logic signed [23:0] y,
                                          logic signed [23:0] z);
    item_t it;
    it = noise_item();
    it.cmd = CMD_PARTICLE;
    it.particle = p;
    it.energy = e;
    it.mom_x = x;
    it.mom_y = y;
    it.mom_z = z;
    return it;
  endfunction

  function automatic item_t read_item(logic [1:0] p, logic [3:0] ci, logic [6:0] bi);
    item_t it;
    it = noise_item();
    it.cmd = CMD_READ;
    it.particle = p;
    it.cut_index = ci;
    it.bin_index = bi;
    return it;
  endfunction

  // near-realistic particle: small momenta, energy in a band
  function automatic item_t rand_particle(logic [1:0] p);
    int lo, hi;
    lo = (p == PART_PSI) ? 3097 : 140;
    hi = (p == PART_PSI) ? 3500 : 450;
    return particle_item(p, 23'($urandom_range(lo, hi)),
                         24'($urandom_range(0, 300)) - 24'sd150,
                         24'($urandom_range(0, 300)) - 24'sd150,
                         24'($urandom_range(0, 300)) - 24'sd150);
  endfunction

  function automatic item_t rand_header();
    logic signed [15:0] s;
    logic [15:0] pm;
    s = 16'($urandom());
    if ($urandom_range(0, 3) == 0) s = 16'($urandom_range(0, 30000));
    pm = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(5700, 6900)) : 16'($urandom());
    return header_item(s, pm);
  endfunction

  function automatic item_t rand_read();
    logic [1:0] p;
    logic [6:0] bi;
    p = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    bi = ($urandom_range(0, 9) == 0) ? 7'($urandom()) : 7'($urandom_range(0, BINS - 1));
    return read_item(p, 4'($urandom()), bi);
  endfunction

  task automatic send_item(item_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 15);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_phase(int ph);
    logic [15:0] v[8];
    case (ph)
      1: v = '{16'h8000, 16'hFFFF, 16'd16, 16'd5800, 16'd1, 16'd3580, 16'd1023, 16'd0};
      2: v = '{16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd0, 16'd0, 16'hFFFF};
      3: v = '{16'hE0C0, 16'd500, 16'd31, 16'd5800, 16'd10, 16'd3400, 16'd20, 16'd6000};
      default: begin
        v[REG_CUT_START]        = 16'($urandom());
        v[REG_CUT_STEP]         = 16'($urandom_range(0, 4000));
        v[REG_CUT_COUNT]        = 16'($urandom_range(1, 16));
        v[REG_PARENT_HIST_LOW]  = 16'($urandom_range(5600, 6000));
        v[REG_PARENT_BIN_WIDTH] = 16'($urandom_range(1, 30));
        v[REG_TRIPLE_HIST_LOW]  = 16'($urandom_range(3300, 3700));
        v[REG_TRIPLE_BIN_WIDTH] = 16'($urandom_range(1, 20));
        v[REG_PARENT_GATE]      = 16'($urandom_range(5800, 6500));
      end
    endcase
    wait_drained();
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_event();
    send_item(rand_header());
    for (int p = 0; p < 4; p++) send_item(rand_particle(2'(p)));
  endtask

  initial begin
    int pick;
    int stop_at;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    sent = 0;
    burst_left = 0;
    rx_mode = 0;
    rx_left = 0;
    rx_hold = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    send_item(header_item(16'sh7FFF, 16'd6500));
    send_item(particle_item(PART_PSI, 23'd3300, 24'sd0, 24'sd0, 24'sd0));
    send_item(particle_item(PART_PIM, 23'd140, 24'sd0, 24'sd0, 24'sd0));
    send_item(particle_item(PART_PIP1, 23'd140, 24'sd0, 24'sd0, 24'sd0));
    send_item(particle_item(PART_PIP2, 23'd180, 24'sd10, 24'sd0, 24'sd0));
    // negative mass square on both masses
    send_item(particle_item(PART_PIP1, 23'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF));
    send_item(particle_item(PART_PIP2, 23'h7FFFFF, 24'sh800000, 24'sh800000, 24'sh800000));
    // gate closed, then reuse of held values
    send_item(header_item(16'sh8000, 16'd0));
    send_item(particle_item(PART_PIP2, 23'd200, 24'sd0, 24'sd0, 24'sd0));
    send_item(header_item(16'sd1, 16'hFFFF));
    send_item(particle_item(PART_PIP2, 23'h7FFFFF, 24'sd0, 24'sd0, 24'sd0));
    send_item(header_item(16'sd0, 16'd5800));
    send_item(read_item(2'(HIST_PARENT), 4'd0, 7'd0));
    send_item(read_item(2'(HIST_PARENT), 4'd15, 7'd70));
    send_item(read_item(2'(HIST_TRIPLE), 4'd0, 7'd0));
    send_item(read_item(2'(HIST_TRIPLE), 4'd1, 7'd99));
    send_item(read_item(2'd2, 4'd0, 7'd0));
    send_item(read_item(2'd3, 4'd0, 7'd0));
    send_item(read_item(2'(HIST_PARENT), 4'd0, 7'd127));
    begin
      item_t it;
      it = noise_item();
      it.cmd = CMD_SPARE;
      send_item(it);
    end

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) set_phase(ph);
      stop_at = sent + PHASE_ITEMS;
      while (sent < stop_at) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          if ($urandom_range(0, 9) == 0) begin
            // broken event: header then a stray particle order
            send_item(rand_header());
            send_item(rand_particle(2'($urandom())));
            send_item(rand_particle(PART_PIP2));
          end else begin
            send_event();
          end
        end else if (pick < 8) begin
          repeat ($urandom_range(1, 6)) send_item(rand_read());
        end else if (pick == 8) begin
          send_item(noise_item());
        end else begin
          send_item(rand_particle(PART_PIP2));
        end
      end
    end

    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cimh_pkg.sv
rtl/cimh_hist_mem.sv
rtl/cut_scan_invariant_mass_histogrammer.sv
rtl/cimh_checker.sv
bench/cimh_checker.sv
bench/tb_top.sv
